### design/lff_pkg.sv
package lff_pkg;

  localparam int LEVEL_W = 8;
  localparam int STEP_W  = 6;
  localparam int SLOT_W  = 8;
  localparam int FUNC_W  = 2;
  localparam int MODE_W  = 2;
  localparam int RAND_W  = 15;

  localparam int PWM_PERIOD = 200;

  localparam int DATA_W = 32;
  localparam int ADDR_W = 5;
  localparam int REG_IDX_W = 3;

  // event codes
  localparam logic [FUNC_W-1:0] FUNC_PWM_TICK    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_EFFECT_TICK = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_BUTTON      = 2'd2;

  // effect modes
  localparam logic [MODE_W-1:0] EFFECT_FLICKER = 2'd0;
  localparam logic [MODE_W-1:0] EFFECT_FADE    = 2'd1;
  localparam logic [MODE_W-1:0] EFFECT_STEADY  = 2'd2;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_FLICKER_MIN  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FLICKER_MAX  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FLICKER_STEP = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FADE_TOP     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FADE_STEP    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_STEADY_LEVEL = 3'd5;

  localparam logic [LEVEL_W-1:0] RST_FLICKER_MIN  = 8'd10;
  localparam logic [LEVEL_W-1:0] RST_FLICKER_MAX  = 8'd100;
  localparam logic [STEP_W-1:0]  RST_FLICKER_STEP = 6'd4;
  localparam logic [LEVEL_W-1:0] RST_FADE_TOP     = 8'd100;
  localparam logic [STEP_W-1:0]  RST_FADE_STEP    = 6'd1;
  localparam logic [LEVEL_W-1:0] RST_STEADY_LEVEL = 8'd200;

  typedef struct packed {
    logic [LEVEL_W-1:0] flicker_min;
    logic [LEVEL_W-1:0] flicker_max;
    logic [STEP_W-1:0]  flicker_step;
    logic [LEVEL_W-1:0] fade_top;
    logic [STEP_W-1:0]  fade_step;
    logic [LEVEL_W-1:0] steady_level;
  } cfg_t;

  // one event as held in the input register
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              flip;   // rand_value mod 10 == 0
  } item_t;

endpackage

### design/lff_cfg_regs.sv
module lff_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lff_pkg::ADDR_W-1:0] paddr,
  input  logic [lff_pkg::DATA_W-1:0] pwdata,
  output logic [lff_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output lff_pkg::cfg_t              cfg
);
  import lff_pkg::*;

  cfg_t                 cfg_r;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flicker_min  <= RST_FLICKER_MIN;
      cfg_r.flicker_max  <= RST_FLICKER_MAX;
      cfg_r.flicker_step <= RST_FLICKER_STEP;
      cfg_r.fade_top     <= RST_FADE_TOP;
      cfg_r.fade_step    <= RST_FADE_STEP;
      cfg_r.steady_level <= RST_STEADY_LEVEL;
    end else if (wr_en) begin
      unique case (idx)
        REG_FLICKER_MIN:  cfg_r.flicker_min  <= pwdata[LEVEL_W-1:0];
        REG_FLICKER_MAX:  cfg_r.flicker_max  <= pwdata[LEVEL_W-1:0];
        REG_FLICKER_STEP: cfg_r.flicker_step <= pwdata[STEP_W-1:0];
        REG_FADE_TOP:     cfg_r.fade_top     <= pwdata[LEVEL_W-1:0];
        REG_FADE_STEP:    cfg_r.fade_step    <= pwdata[STEP_W-1:0];
        REG_STEADY_LEVEL: cfg_r.steady_level <= pwdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FLICKER_MIN:  prdata = DATA_W'(cfg_r.flicker_min);
      REG_FLICKER_MAX:  prdata = DATA_W'(cfg_r.flicker_max);
      REG_FLICKER_STEP: prdata = DATA_W'(cfg_r.flicker_step);
      REG_FADE_TOP:     prdata = DATA_W'(cfg_r.fade_top);
      REG_FADE_STEP:    prdata = DATA_W'(cfg_r.fade_step);
      REG_STEADY_LEVEL: prdata = DATA_W'(cfg_r.steady_level);
      default:          prdata = '0;
    endcase
  end

endmodule

### design/lff_in_stage.sv
module lff_in_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [lff_pkg::FUNC_W-1:0] in_func,
  input  logic [lff_pkg::RAND_W-1:0] in_rand_value,
  output logic                       item_valid,
  input  logic                       item_take,
  output lff_pkg::item_t             item
);
  import lff_pkg::*;

  logic       valid_r;
  item_t      item_r;
  logic [5:0] digit_sum;
  logic [4:0] fold;
  logic       by_five;
  logic       flip;

  // 16 = 1 mod 5: summing hex digits keeps the residue
  assign digit_sum = 6'({1'b0, in_rand_value[14:12]}) + 6'(in_rand_value[11:8])
                   + 6'(in_rand_value[7:4]) + 6'(in_rand_value[3:0]);
  assign fold      = 5'(digit_sum[5:4]) + 5'(digit_sum[3:0]);
  assign by_five   = (fold == 5'd0) || (fold == 5'd5) || (fold == 5'd10) ||
                     (fold == 5'd15);
  assign flip      = by_five && !in_rand_value[0];

  assign in_ready   = !valid_r || item_take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.func <= in_func;
      item_r.flip <= flip;
    end
  end

endmodule

### design/lff_engine.sv
module lff_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lff_pkg::cfg_t               cfg,
  input  logic                        item_valid,
  output logic                        item_take,
  input  lff_pkg::item_t              item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_led_on,
  output logic [lff_pkg::LEVEL_W-1:0] out_level_now,
  output logic [lff_pkg::MODE_W-1:0]  out_mode_now,
  output logic                        out_rising_now
);
  import lff_pkg::*;

  function automatic logic [LEVEL_W-1:0] move_level(input logic [LEVEL_W-1:0] lv,
                                                    input logic [STEP_W-1:0]  step,
                                                    input logic               up);
    logic [LEVEL_W:0] sum;
    logic [LEVEL_W-1:0] res;
    sum = {1'b0, lv} + (LEVEL_W+1)'(step);
    if (up) begin
      res = sum[LEVEL_W] ? '1 : sum[LEVEL_W-1:0];
    end else begin
      res = (LEVEL_W'(step) > lv) ? '0 : lv - LEVEL_W'(step);
    end
    return res;
  endfunction

  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic               rising_r, rising_nxt;
  logic [MODE_W-1:0]  mode_r, mode_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;

  logic               out_valid_r;
  logic               led_r;
  logic [LEVEL_W-1:0] out_level_r;
  logic [MODE_W-1:0]  out_mode_r;
  logic               out_rising_r;

  logic [SLOT_W:0]    slot_inc;
  logic [LEVEL_W-1:0] flick_mv;
  logic [LEVEL_W-1:0] flick_lo;
  logic               fade_dir;

  assign item_take = item_valid && (!out_valid_r || out_ready);

  assign slot_inc = {1'b0, slot_r} + (SLOT_W+1)'(1);
  assign flick_mv = move_level(level_r, cfg.flicker_step, rising_r);
  assign flick_lo = (flick_mv < cfg.flicker_min) ? cfg.flicker_min : flick_mv;
  assign fade_dir = rising_r ^ ((level_r == '0) || (level_r > cfg.fade_top));

  always_comb begin
    level_nxt  = level_r;
    rising_nxt = rising_r;
    mode_nxt   = mode_r;
    slot_nxt   = slot_r;
    case (item.func)
      FUNC_PWM_TICK: begin
        slot_nxt = (slot_inc >= (SLOT_W+1)'(PWM_PERIOD)) ? '0 : slot_inc[SLOT_W-1:0];
      end
      FUNC_EFFECT_TICK: begin
        case (mode_r)
          EFFECT_FLICKER: begin
            // upper clamp last: an inverted band lands on flicker_max
            level_nxt  = (flick_lo >= cfg.flicker_max) ? cfg.flicker_max : flick_lo;
            rising_nxt = rising_r ^ item.flip;
          end
          EFFECT_FADE: begin
            rising_nxt = fade_dir;
            level_nxt  = move_level(level_r, cfg.fade_step, fade_dir);
          end
          default: level_nxt = cfg.steady_level;
        endcase
      end
      FUNC_BUTTON: begin
        level_nxt  = '0;
        rising_nxt = 1'b0;
        case (mode_r)
          EFFECT_FLICKER: mode_nxt = EFFECT_FADE;
          EFFECT_FADE:    mode_nxt = EFFECT_STEADY;
          EFFECT_STEADY:  mode_nxt = EFFECT_FLICKER;
          default:        mode_nxt = EFFECT_FADE;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= '0;
      rising_r    <= 1'b0;
      mode_r      <= EFFECT_STEADY;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (item_take) begin
        level_r  <= level_nxt;
        rising_r <= rising_nxt;
        mode_r   <= mode_nxt;
        slot_r   <= slot_nxt;
      end
      if (item_take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register; led uses the slot before its advance
  always_ff @(posedge clk) begin
    if (item_take) begin
      led_r        <= (slot_r < level_nxt);
      out_level_r  <= level_nxt;
      out_mode_r   <= mode_nxt;
      out_rising_r <= rising_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_led_on     = led_r;
  assign out_level_now  = out_level_r;
  assign out_mode_now   = out_mode_r;
  assign out_rising_now = out_rising_r;

`ifndef SYNTH
  a_slot_in_period: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r < SLOT_W'(PWM_PERIOD))
    else $error("pwm slot outside period");

  a_button_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (item_take && item.func == FUNC_BUTTON) |=>
      (out_valid_r && level_r == '0 && !rising_r))
    else $error("button beat did not clear level and direction");

  a_led_needs_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && led_r) |-> (out_level_r != '0))
    else $error("led on with zero level");

  a_slot_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (item_take && item.func != FUNC_PWM_TICK) |=> $stable(slot_r))
    else $error("slot moved on non-pwm beat");

  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    item_take |=> (out_level_r == level_r && out_mode_r == mode_r &&
                   out_rising_r == rising_r))
    else $error("result register out of step with state");
`endif

endmodule

### design/led_flicker_fade_pwm_core.sv
// LED effect controller: flicker, fade and steady brightness, plus PWM drive.
// Input channel (in_valid/in_ready) carries one event per beat: in_func picks
// a PWM slot tick, an effect tick or a button press; in_rand_value feeds the
// flicker direction flip (flips when the value is a multiple of ten).
// Result channel (out_valid/out_ready) returns one beat per event: LED drive,
// level, mode and direction as they stand after that event.
// Two register stages: an input register (which also works out the mod-ten
// test), then one pass of update logic into the state and result registers.
// out_valid rises once an event has passed the input register and the update logic
// into the result register. Throughput is one event per cycle while the receiver
// keeps out_ready high; the state feedback loop (level, direction, mode, slot)
// sets that. A stalled receiver holds the result register; the input register
// still takes one more beat, after which in_ready drops until out_ready
// returns.
// Reset (rst_n, synchronous): level 0, direction falling, mode steady, slot 0,
// registers back to their defaults, both channels empty.
// Settings via APB-style port at byte address 4*index; pready is tied high
// and writes land on the access cycle. Write only while the block is idle.
module led_flicker_fade_pwm_core (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lff_pkg::ADDR_W-1:0]  paddr,
  input  logic [lff_pkg::DATA_W-1:0]  pwdata,
  output logic [lff_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  // events
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lff_pkg::FUNC_W-1:0]  in_func,
  input  logic [lff_pkg::RAND_W-1:0]  in_rand_value,
  // results
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_led_on,
  output logic [lff_pkg::LEVEL_W-1:0] out_level_now,
  output logic [lff_pkg::MODE_W-1:0]  out_mode_now,
  output logic                        out_rising_now
);
  import lff_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  logic  item_take;

  lff_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register; mod-ten test done here to keep the update path short
  lff_in_stage u_in (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_rand_value (in_rand_value),
    .item_valid    (item_valid),
    .item_take     (item_take),
    .item          (item)
  );

  // state update and result register
  lff_engine u_eng (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .item_valid     (item_valid),
    .item_take      (item_take),
    .item           (item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_led_on     (out_led_on),
    .out_level_now  (out_level_now),
    .out_mode_now   (out_mode_now),
    .out_rising_now (out_rising_now)
  );

endmodule
